### hdl/pdrm_pkg.sv
// ----------------------------------------------------------------------------
// Descriptor ring manager package
// Shared field widths, event and status codes, and the request and result
// payload types for the packet descriptor ring manager.
// ----------------------------------------------------------------------------
package pdrm_pkg;

    // Field widths of the request and result payloads.
    localparam int FUNC_W   = 3;
    localparam int LEN_W    = 11;
    localparam int SIZE_W   = 16;
    localparam int PHY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;

    // Bit of the PHY basic status word that reports link up.
    localparam int PHY_LINK_BIT = 2;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Event codes.
    localparam func_t FUNC_TX_SUBMIT = 3'd0;
    localparam func_t FUNC_TX_DONE   = 3'd1;
    localparam func_t FUNC_RX_DONE   = 3'd2;
    localparam func_t FUNC_RX_READ   = 3'd3;
    localparam func_t FUNC_LINK      = 3'd4;

    // Transmit submit status codes.
    localparam status_t STATUS_OK         = 2'd0;
    localparam status_t STATUS_LINK_DOWN  = 2'd1;
    localparam status_t STATUS_QUEUE_FULL = 2'd2;

    typedef struct packed {
        func_t             func;
        logic [LEN_W-1:0]  length;
        logic [SIZE_W-1:0] buffer_size;
        logic [PHY_W-1:0]  phy_status;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic               launch;
        logic [SLOT_W-1:0]  launch_slot;
        logic [LEN_W-1:0]   launch_length;
        logic [LEN_W-1:0]   read_length;
        logic [SLOT_W-1:0]  read_slot;
        logic [SLOT_W-1:0]  fill_slot;
        logic [COUNT_W-1:0] pending_count;
        logic [LEN_W-1:0]   head_length;
        logic               send_enabled;
    } rsp_t;

endpackage

### hdl/pdrm_req_if.sv
// ----------------------------------------------------------------------------
// Descriptor ring manager request channel
// Valid/ready channel that carries one event request per handshake.
// ----------------------------------------------------------------------------
interface pdrm_req_if
    import pdrm_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/pdrm_rsp_if.sv
// ----------------------------------------------------------------------------
// Descriptor ring manager result channel
// Valid/ready channel that carries one result per handshake.
// ----------------------------------------------------------------------------
interface pdrm_rsp_if
    import pdrm_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/packet_descriptor_ring_manager_top.sv
// ----------------------------------------------------------------------------
// Packet descriptor ring manager
// Tracks transmit and receive descriptor rings of an Ethernet MAC by slot
// index and frame length.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one event per request: transmit submit, transmit
// done, receive done, receive read or link change. Every request produces
// exactly one result on the rsp channel, in request order.
// A request is captured in an input register; the event logic then
// updates the ring pointers and length registers and loads the result
// register once the result register is free. One request is taken every
// cycle while the result channel does not stall; the event logic between
// the two registers is combinational.
// Reset clears all ring pointers and counts, disables transmit until a
// link change reports link up, and empties both registers.
// When the receiver stalls, the result register holds its result, one
// more request is kept in the input register, and ready then drops until
// the result is taken. Ring lengths are stored in small register files.
// ----------------------------------------------------------------------------
module packet_descriptor_ring_manager_top
    import pdrm_pkg::*;
#(
    parameter int TX_SLOTS = 4,
    parameter int RX_SLOTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    pdrm_req_if.sink    req,
    pdrm_rsp_if.source  rsp
);

    localparam int TX_IDX_W = $clog2(TX_SLOTS);
    localparam int TX_CNT_W = $clog2(TX_SLOTS + 1);
    localparam int RX_IDX_W = $clog2(RX_SLOTS);
    localparam int RX_CNT_W = $clog2(RX_SLOTS + 1);

    localparam logic [TX_IDX_W-1:0] TX_LAST  = TX_IDX_W'(TX_SLOTS - 1);
    localparam logic [TX_CNT_W-1:0] TX_FULL  = TX_CNT_W'(TX_SLOTS);
    localparam logic [RX_IDX_W-1:0] RX_LAST  = RX_IDX_W'(RX_SLOTS - 1);
    localparam logic [RX_CNT_W-1:0] RX_LIMIT = RX_CNT_W'(RX_SLOTS - 1);

    // Wrapping ring pointer increments.
    function automatic logic [TX_IDX_W-1:0] tx_inc(input logic [TX_IDX_W-1:0] p);
        return (p == TX_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RX_IDX_W-1:0] rx_inc(input logic [RX_IDX_W-1:0] p);
        return (p == RX_LAST) ? '0 : p + 1'b1;
    endfunction

    // Pipeline registers.
    logic in_valid_reg;
    req_t in_data_reg;
    logic out_valid_reg;
    rsp_t out_data_reg;
    rsp_t out_data_next;

    // Transmit ring state.
    logic [LEN_W-1:0]    tx_len_reg [TX_SLOTS];
    logic [TX_IDX_W-1:0] tx_wr_reg, tx_wr_next;
    logic [TX_IDX_W-1:0] tx_send_reg, tx_send_next;
    logic [TX_CNT_W-1:0] tx_queued_reg, tx_queued_next;
    logic                tx_len_we;
    logic                link_en_reg, link_en_next;

    // Receive ring state. The head register mirrors the length at the read
    // position whenever a frame is pending.
    logic [LEN_W-1:0]    rx_len_reg [RX_SLOTS];
    logic [RX_IDX_W-1:0] rx_fill_reg, rx_fill_next;
    logic [RX_IDX_W-1:0] rx_read_reg, rx_read_next;
    logic [RX_CNT_W-1:0] rx_pending_reg, rx_pending_next;
    logic [LEN_W-1:0]    rx_head_reg, rx_head_next;
    logic                rx_len_we;

    logic advance;

    // The event stage advances whenever the result register is free.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // Input and result valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_data_reg <= req.data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
            rx_head_reg  <= rx_head_next;
        end
    end

    // Ring length register files.
    always_ff @(posedge clk)
    begin
        if (advance && tx_len_we)
        begin
            tx_len_reg[tx_wr_reg] <= in_data_reg.length;
        end
        if (advance && rx_len_we)
        begin
            rx_len_reg[rx_fill_reg] <= in_data_reg.length;
        end
    end

    // Ring pointers, counts and link enable.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_wr_reg      <= '0;
            tx_send_reg    <= '0;
            tx_queued_reg  <= '0;
            link_en_reg    <= 1'b0;
            rx_fill_reg    <= '0;
            rx_read_reg    <= '0;
            rx_pending_reg <= '0;
        end
        else if (advance)
        begin
            tx_wr_reg      <= tx_wr_next;
            tx_send_reg    <= tx_send_next;
            tx_queued_reg  <= tx_queued_next;
            link_en_reg    <= link_en_next;
            rx_fill_reg    <= rx_fill_next;
            rx_read_reg    <= rx_read_next;
            rx_pending_reg <= rx_pending_next;
        end
    end

    // Event logic: next ring state and the result of the held request.
    always_comb
    begin
        tx_wr_next      = tx_wr_reg;
        tx_send_next    = tx_send_reg;
        tx_queued_next  = tx_queued_reg;
        link_en_next    = link_en_reg;
        rx_fill_next    = rx_fill_reg;
        rx_read_next    = rx_read_reg;
        rx_pending_next = rx_pending_reg;
        rx_head_next    = rx_head_reg;
        tx_len_we       = 1'b0;
        rx_len_we       = 1'b0;
        out_data_next   = '0;

        case (in_data_reg.func)
            FUNC_TX_SUBMIT:
            begin
                if (!link_en_reg)
                begin
                    out_data_next.status = STATUS_LINK_DOWN;
                end
                else if (tx_queued_reg == TX_FULL)
                begin
                    out_data_next.status = STATUS_QUEUE_FULL;
                end
                else
                begin
                    tx_len_we  = 1'b1;
                    tx_wr_next = tx_inc(tx_wr_reg);
                    if (tx_queued_reg == '0)
                    begin
                        // Empty queue: the new frame launches at once.
                        out_data_next.launch        = 1'b1;
                        out_data_next.launch_slot   = SLOT_W'(tx_wr_reg);
                        out_data_next.launch_length = in_data_reg.length;
                        tx_send_next                = tx_inc(tx_send_reg);
                    end
                    else
                    begin
                        tx_queued_next = tx_queued_reg + 1'b1;
                    end
                end
            end
            FUNC_TX_DONE:
            begin
                if (tx_queued_reg != '0)
                begin
                    out_data_next.launch        = 1'b1;
                    out_data_next.launch_slot   = SLOT_W'(tx_send_reg);
                    out_data_next.launch_length = tx_len_reg[tx_send_reg];
                    tx_send_next                = tx_inc(tx_send_reg);
                    tx_queued_next              = tx_queued_reg - 1'b1;
                end
            end
            FUNC_RX_DONE:
            begin
                // With one slot left the fill slot is overwritten in place.
                rx_len_we = 1'b1;
                if (rx_pending_reg < RX_LIMIT)
                begin
                    rx_pending_next = rx_pending_reg + 1'b1;
                    rx_fill_next    = rx_inc(rx_fill_reg);
                    if (rx_pending_reg == '0)
                    begin
                        rx_head_next = in_data_reg.length;
                    end
                end
            end
            FUNC_RX_READ:
            begin
                if (rx_pending_reg != '0)
                begin
                    if (SIZE_W'(rx_head_reg) < in_data_reg.buffer_size)
                    begin
                        out_data_next.read_length = rx_head_reg;
                    end
                    else
                    begin
                        out_data_next.read_length = in_data_reg.buffer_size[LEN_W-1:0];
                    end
                    out_data_next.read_slot = SLOT_W'(rx_read_reg);
                    rx_read_next            = rx_inc(rx_read_reg);
                    rx_pending_next         = rx_pending_reg - 1'b1;
                    rx_head_next            = rx_len_reg[rx_inc(rx_read_reg)];
                end
            end
            FUNC_LINK:
            begin
                link_en_next = in_data_reg.phy_status[PHY_LINK_BIT];
            end
            default:
            begin
                // Unknown events only report the current state.
            end
        endcase

        // Receive ring status after the event.
        out_data_next.fill_slot     = SLOT_W'(rx_fill_next);
        out_data_next.pending_count = COUNT_W'(rx_pending_next);
        out_data_next.head_length   = (rx_pending_next != '0) ? rx_head_next : '0;
        out_data_next.send_enabled  = link_en_next;
    end

endmodule

### hdl/pdrm_checker.sv
// ----------------------------------------------------------------------------
// Descriptor ring manager checker
// Port-level assertions on the result channel of the ring manager.
// ----------------------------------------------------------------------------
module pdrm_checker
    import pdrm_pkg::*;
#(
    parameter int RX_SLOTS = 4
)
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    localparam logic [COUNT_W-1:0] PENDING_MAX = COUNT_W'(RX_SLOTS - 1);

    // A result without a launch carries no launch slot or length.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.launch |->
            rsp_data.launch_slot == '0 && rsp_data.launch_length == '0)
    else $error("launch fields set without a launch");

    // A refused submit neither launches nor delivers a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != STATUS_OK |->
            !rsp_data.launch && rsp_data.read_length == '0)
    else $error("refused submit launched or delivered a frame");

    // An empty receive ring reports no head length, and one slot stays free.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |->
            rsp_data.pending_count <= PENDING_MAX &&
            (rsp_data.pending_count != '0 || rsp_data.head_length == '0))
    else $error("receive ring count or head length out of range");

    // A stalled result is held until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed");

endmodule

bind packet_descriptor_ring_manager_top pdrm_checker #(
    .RX_SLOTS (RX_SLOTS)
) u_pdrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Descriptor ring manager testbench
// Sends transmit, receive and link events through the request channel and
// checks every result against a cycle-free model of the transmit and
// receive rings. The model is kept inside this module. The run covers
// directed corner events, random traffic with gaps on both channels, a long
// stall of the result channel, and random traffic at full rate.
// ----------------------------------------------------------------------------
module testbench;
    import pdrm_pkg::*;

    localparam int TX_SLOTS       = 4;
    localparam int RX_SLOTS       = 4;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;

    pdrm_req_if req_ch ();
    pdrm_rsp_if rsp_ch ();

    packet_descriptor_ring_manager_top #(
        .TX_SLOTS (TX_SLOTS),
        .RX_SLOTS (RX_SLOTS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Ring model state, starting from the block's reset state.
    logic [LEN_W-1:0] tx_len_ring [TX_SLOTS];
    logic [LEN_W-1:0] rx_len_ring [RX_SLOTS];
    int tx_wr_idx      = 0;
    int tx_send_idx    = 0;
    int tx_queue_depth = 0;
    int rx_fill_idx    = 0;
    int rx_read_idx    = 0;
    int rx_waiting     = 0;
    logic link_up      = 1'b0;

    rsp_t expected_results [$];
    int   mismatch_count = 0;
    int   result_index   = 0;
    int   quiet_cycles   = 0;
    int   hold_request   = 0;
    logic sender_gaps_on    = 1'b1;
    logic receiver_stalls_on = 1'b1;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one event to the ring model and return the result it causes.
    function automatic rsp_t predict_ring_event(req_t r);
        rsp_t res;
        logic start_tx;
        logic [LEN_W-1:0] frame_len;
        res = '0;
        start_tx = 1'b0;
        case (r.func)
            FUNC_TX_SUBMIT:
            begin
                if (!link_up)
                    res.status = STATUS_LINK_DOWN;
                else if (tx_queue_depth >= TX_SLOTS)
                    res.status = STATUS_QUEUE_FULL;
                else
                begin
                    tx_len_ring[tx_wr_idx] = r.length;
                    tx_wr_idx = (tx_wr_idx + 1) % TX_SLOTS;
                    tx_queue_depth++;
                    start_tx = (tx_queue_depth == 1);
                end
            end
            FUNC_TX_DONE:
                start_tx = (tx_queue_depth != 0);
            FUNC_RX_DONE:
            begin
                // With only one slot free the last slot is overwritten in place.
                rx_len_ring[rx_fill_idx] = r.length;
                if (rx_waiting < RX_SLOTS - 1)
                begin
                    rx_waiting++;
                    rx_fill_idx = (rx_fill_idx + 1) % RX_SLOTS;
                end
            end
            FUNC_RX_READ:
            begin
                if (rx_waiting != 0)
                begin
                    frame_len = rx_len_ring[rx_read_idx];
                    res.read_length = (frame_len < r.buffer_size) ?
                                      frame_len : r.buffer_size[LEN_W-1:0];
                    res.read_slot = SLOT_W'(rx_read_idx);
                    rx_read_idx = (rx_read_idx + 1) % RX_SLOTS;
                    rx_waiting--;
                end
            end
            FUNC_LINK:
                link_up = r.phy_status[PHY_LINK_BIT];
            default:
                ;
        endcase

        // Launch the frame at the send position.
        if (start_tx)
        begin
            res.launch        = 1'b1;
            res.launch_slot   = SLOT_W'(tx_send_idx);
            res.launch_length = tx_len_ring[tx_send_idx];
            tx_send_idx = (tx_send_idx + 1) % TX_SLOTS;
            tx_queue_depth--;
        end

        res.fill_slot     = SLOT_W'(rx_fill_idx);
        res.pending_count = COUNT_W'(rx_waiting);
        if (rx_waiting != 0)
            res.head_length = rx_len_ring[rx_read_idx];
        res.send_enabled = link_up;
        return res;
    endfunction

    function automatic req_t build_event(func_t f, int unsigned len, int unsigned size,
                                         int unsigned phy);
        req_t r;
        r.func        = f;
        r.length      = LEN_W'(len);
        r.buffer_size = SIZE_W'(size);
        r.phy_status  = PHY_W'(phy);
        return r;
    endfunction

    // Send one request, with an optional gap in front, and record its expected result.
    task automatic send_event(req_t r);
        if (sender_gaps_on && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_results.push_back(predict_ring_event(r));
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                      result_index, name, got, want));
    endtask

    // Random event fields, biased toward the extremes.
    function automatic int unsigned random_length();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 2047;
            default: return $urandom_range(0, 2047);
        endcase
    endfunction

    function automatic int unsigned random_buffer_size();
        case ($urandom_range(0, 7))
            0, 1: return $urandom_range(0, 64);
            2: return 16'hFFFF;
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    function automatic int unsigned random_phy_status();
        int unsigned phy;
        phy = $urandom_range(0, 16'hFFFF);
        // Keep the link up most of the time so that submits go through.
        if ($urandom_range(0, 3) != 0)
            phy = phy | (1 << PHY_LINK_BIT);
        return phy;
    endfunction

    // Corner events: link down submit, empty queues, clamping, ring overwrite.
    task automatic test_directed_events();
        send_event(build_event(FUNC_TX_SUBMIT, 2047, 0, 0));
        send_event(build_event(FUNC_TX_DONE, 0, 0, 0));
        send_event(build_event(FUNC_RX_READ, 0, 16'hFFFF, 0));
        send_event(build_event(FUNC_LINK, 0, 0, 16'hFFFB));
        send_event(build_event(FUNC_TX_SUBMIT, 100, 0, 0));
        send_event(build_event(FUNC_LINK, 0, 0, 16'h0004));
        send_event(build_event(FUNC_TX_SUBMIT, 0, 0, 0));
        send_event(build_event(FUNC_TX_SUBMIT, 2047, 0, 0));
        send_event(build_event(FUNC_TX_SUBMIT, 1234, 0, 0));
        send_event(build_event(FUNC_TX_DONE, 0, 0, 0));
        send_event(build_event(FUNC_RX_DONE, 2047, 0, 0));
        send_event(build_event(FUNC_RX_DONE, 0, 0, 0));
        send_event(build_event(FUNC_RX_DONE, 5, 0, 0));
        send_event(build_event(FUNC_RX_DONE, 100, 0, 0));
        send_event(build_event(FUNC_RX_DONE, 2046, 16'hFFFF, 16'hFFFF));
        send_event(build_event(FUNC_RX_READ, 0, 1000, 0));
        send_event(build_event(FUNC_RX_READ, 0, 16'hFFFF, 0));
        send_event(build_event(FUNC_RX_READ, 0, 3, 0));
        send_event(build_event(FUNC_RX_READ, 0, 16'hFFFF, 0));
        send_event(build_event(3'd5, 2047, 16'hFFFF, 16'hFFFF));
        send_event(build_event(3'd6, 0, 0, 0));
        send_event(build_event(3'd7, 1, 1, 1));
        send_event(build_event(FUNC_LINK, 0, 0, 16'h0000));
        send_event(build_event(FUNC_TX_SUBMIT, 7, 0, 0));
        send_event(build_event(FUNC_LINK, 0, 0, 16'hFFFF));
    endtask

    // Mixed traffic, mostly submits, receive completions and reads.
    task automatic test_random_traffic(int count);
        int pick;
        func_t f;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                f = FUNC_LINK;
            else if (pick < 30)
                f = FUNC_TX_SUBMIT;
            else if (pick < 40)
                f = FUNC_TX_DONE;
            else if (pick < 66)
                f = FUNC_RX_DONE;
            else if (pick < 96)
                f = FUNC_RX_READ;
            else
                f = func_t'($urandom_range(5, 7));
            send_event(build_event(f, random_length(), random_buffer_size(),
                                   random_phy_status()));
        end
    endtask

    // Hold the result channel for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        hold_request = HOLD_CYCLES;
        wait (hold_request == 0);
        for (int n = 0; n < 24; n++)
            send_event(build_event((n % 2 == 0) ? FUNC_RX_DONE : FUNC_RX_READ,
                                   random_length(), random_buffer_size(), 0));
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    // Result channel ready, with short random stalls and one long hold.
    initial
    begin
        int n;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                n = hold_request;
                hold_request = 0;
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else if (receiver_stalls_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_checker
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                          result_index));
            else
            begin
                want = expected_results.pop_front();
                check_field("status", rsp_ch.data.status, want.status);
                check_field("launch", rsp_ch.data.launch, want.launch);
                check_field("launch_slot", rsp_ch.data.launch_slot, want.launch_slot);
                check_field("launch_length", rsp_ch.data.launch_length, want.launch_length);
                check_field("read_length", rsp_ch.data.read_length, want.read_length);
                check_field("read_slot", rsp_ch.data.read_slot, want.read_slot);
                check_field("fill_slot", rsp_ch.data.fill_slot, want.fill_slot);
                check_field("pending_count", rsp_ch.data.pending_count, want.pending_count);
                check_field("head_length", rsp_ch.data.head_length, want.head_length);
                check_field("send_enabled", rsp_ch.data.send_enabled, want.send_enabled);
            end
            result_index++;
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("packet_descriptor_ring_manager_top test failed");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_events();
        test_random_traffic(600);
        test_output_backpressure();

        // Full rate on both channels for the last part.
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        test_random_traffic(600);
        req_ch.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("packet_descriptor_ring_manager_top test passed");
        else
            $display("packet_descriptor_ring_manager_top test failed");
        $finish;
    end

endmodule
